// ----- hdl/cpmd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpmd_pkg
// Shared types and constants of the cascaded PID motor drive: configuration
// register codes, reset values and the packed loop coefficient layout.
// ----------------------------------------------------------------------------
package cpmd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DUTY_W     = 11;
  localparam int LOOPS      = 3;
  localparam int ENABLES_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_COEFFS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_COEFFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_COEFFS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT   = 3'd4;

  localparam logic [ENABLES_W-1:0] ENABLES_RESET    = 3'd3;
  localparam logic [DUTY_W-1:0]    DUTY_LIMIT_RESET = 11'd512;

  typedef struct packed {
    logic [15:0] lim;
    logic [15:0] kd;
    logic [15:0] ki;
    logic [15:0] kp;
  } loop_coeffs_t;

  typedef struct packed {
    loop_coeffs_t [LOOPS-1:0] coeffs;
    logic [ENABLES_W-1:0]     enables;
    logic [DUTY_W-1:0]        duty_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/cpmd_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpmd_cfg
// Configuration register file: loop coefficients, loop enables and the duty
// limit, written through a plain write port.
// ----------------------------------------------------------------------------
module cpmd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wen,
  input  wire logic [cpmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cpmd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cpmd_pkg::cfg_t                        cfg_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeffs     <= '0;
      cfg_r.enables    <= cpmd_pkg::ENABLES_RESET;
      cfg_r.duty_limit <= cpmd_pkg::DUTY_LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        cpmd_pkg::CFG_POS_COEFFS:   cfg_r.coeffs[0]  <= cfg_wdata;
        cpmd_pkg::CFG_SPD_COEFFS:   cfg_r.coeffs[1]  <= cfg_wdata;
        cpmd_pkg::CFG_CUR_COEFFS:   cfg_r.coeffs[2]  <= cfg_wdata;
        cpmd_pkg::CFG_LOOP_ENABLES: cfg_r.enables    <= cfg_wdata[cpmd_pkg::ENABLES_W-1:0];
        cpmd_pkg::CFG_DUTY_LIMIT:   cfg_r.duty_limit <= cfg_wdata[cpmd_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/cpmd_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpmd_mul
// Shared registered multiplier: signed 33-bit operand times unsigned 32-bit
// operand, product registered in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module cpmd_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] op_a,
  input  wire logic        [31:0] op_b,
  output logic signed      [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * $signed({1'b0, op_b});
  end

endmodule
`default_nettype wire

// ----- hdl/cascaded_pid_motor_drive.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_pid_motor_drive
// Position, speed and current PID cascade per drive channel, with duty output.
// ----------------------------------------------------------------------------
// One transaction is one control tick for one drive. All products are formed
// on a single registered multiplier under a small sequencer, so the block takes
// one transaction at a time: an enabled loop steps through the error, three
// products for P, I and D, and the sum; a disabled loop through the error step
// only; scaling the current reference by REDUCTION through its division steps;
// and the output stage waits until the output register is free. A tick for a
// drive number at or above DRIVES skips the loops and returns an all-zero
// result. A finished result waits in the output register while the next
// transaction is accepted. Configuration writes are expected only while the
// block is idle.
module cascaded_pid_motor_drive #(
  parameter int DRIVES         = 4,
  parameter int PWM_FULL_SCALE = 1024,
  parameter int CURRENT_ZERO   = 0,
  parameter int REDUCTION      = 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // encoder_position[31:0], current_sample[47:32], position_target[79:48],
  // torque_offset[95:80]
  input  wire logic [95:0]                      in_tdata,
  // drive_index[1:0]
  input  wire logic [1:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // duty[10:0], forward[11], direction_changed[12], zero[15:13]
  output logic [15:0]                           out_tdata,
  input  wire logic                             cfg_wen,
  input  wire logic [cpmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cpmd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int DRV_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int MAG_W = $clog2(PWM_FULL_SCALE + 1);
  localparam logic [31:0]        RECIP  = 32'(64'hFFFF_FFFF / 64'(REDUCTION));
  localparam logic signed [31:0] FS_POS = 32'(PWM_FULL_SCALE);
  localparam logic signed [31:0] FS_NEG = -FS_POS;
  localparam logic [MAG_W-1:0]   FS_MAG = MAG_W'(PWM_FULL_SCALE);

  localparam logic [1:0] LOOP_POS = 2'd0;
  localparam logic [1:0] LOOP_SPD = 2'd1;
  localparam logic [1:0] LOOP_CUR = 2'd2;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_ERR  = 10'b00_0000_0010,
    S_MP   = 10'b00_0000_0100,
    S_MI   = 10'b00_0000_1000,
    S_MD   = 10'b00_0001_0000,
    S_SUM  = 10'b00_0010_0000,
    S_DIV0 = 10'b00_0100_0000,
    S_DIV1 = 10'b00_1000_0000,
    S_DIV2 = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v[49:31] == {19{v[49]}}) begin
      return v[31:0];
    end
    return v[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  cpmd_pkg::cfg_t cfg;

  cpmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  state_t state_r, state_nxt;
  logic [1:0] lp_r, lp_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [15:0] out_tdata_r;

  logic [DRV_W-1:0] drv_r;
  logic             drv_ok_r;
  logic signed [31:0] pos_r, target_r, speed_r, err_r, sp_r;
  logic signed [16:0] cur_fb_r;
  logic signed [15:0] torque_r;
  logic signed [39:0] pterm_r;
  logic        [31:0] quo_r;

  logic signed [31:0] last_pos_r [DRIVES];
  logic signed [31:0] integ_r    [DRIVES][cpmd_pkg::LOOPS];
  logic signed [31:0] perr_r     [DRIVES][cpmd_pkg::LOOPS];
  logic               dir_flag_r  [DRIVES];
  logic               dir_valid_r [DRIVES];

  logic signed [32:0] mul_a;
  logic        [31:0] mul_b;
  logic signed [65:0] prod_r;

  cpmd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  logic                   accept;
  logic                   out_free;
  logic [DRV_W-1:0]       drv_in;
  logic                   drv_in_ok;
  logic signed [31:0]     pos_in;
  logic signed [16:0]     samp_ext;
  logic signed [16:0]     cur_fb_in;
  logic signed [31:0]     speed_in;
  cpmd_pkg::loop_coeffs_t co;
  logic                   loop_en;
  logic signed [31:0]     integ_cur;
  logic signed [31:0]     perr_cur;
  logic signed [33:0]     err_raw;
  logic signed [39:0]     iterm;
  logic signed [40:0]     dterm;
  logic signed [31:0]     i_acc;
  logic signed [32:0]     lim_pos;
  logic signed [31:0]     integ_nxt;
  logic                   sp_neg;
  logic        [31:0]     sp_abs;
  logic        [32:0]     div_rem;
  logic        [31:0]     quo_fix;
  logic        [MAG_W-1:0] mag;
  logic                   fwd;
  logic [cpmd_pkg::DUTY_W-1:0] duty;
  logic                   dir_chg;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign drv_in    = DRV_W'(in_tuser);
  assign drv_in_ok = int'(in_tuser) < DRIVES;
  assign pos_in    = $signed(in_tdata[31:0]);
  assign samp_ext  = 17'($signed(in_tdata[47:32]));
  assign cur_fb_in = (samp_ext[16] ? -samp_ext : samp_ext) - 17'(CURRENT_ZERO);
  assign speed_in  = sat32(50'(pos_in) - 50'(last_pos_r[drv_in]));

  assign co        = cfg.coeffs[lp_r];
  assign loop_en   = cfg.enables[lp_r];
  assign integ_cur = integ_r[drv_r][lp_r];
  assign perr_cur  = perr_r[drv_r][lp_r];

  always_comb begin
    unique case (lp_r)
      LOOP_POS: err_raw = 34'(target_r) - 34'(pos_r);
      LOOP_SPD: err_raw = 34'(sp_r) - 34'(speed_r);
      default:  err_raw = 34'(sp_r) + 34'(torque_r) - 34'(cur_fb_r);
    endcase
  end

  assign iterm   = $signed(prod_r[47:8]);
  assign dterm   = (co.kd != '0) ? $signed(prod_r[48:8]) : '0;
  assign i_acc   = sat32(50'(integ_cur) + 50'(iterm));
  assign lim_pos = {17'd0, co.lim};

  always_comb begin
    if (33'(i_acc) > lim_pos) begin
      integ_nxt = 32'(lim_pos);
    end else if (33'(i_acc) < -lim_pos) begin
      integ_nxt = 32'(-lim_pos);
    end else begin
      integ_nxt = i_acc;
    end
  end

  assign sp_neg  = sp_r[31];
  assign sp_abs  = sp_neg ? 32'(-sp_r) : sp_r;
  assign div_rem = {1'b0, sp_abs} - prod_r[32:0];
  assign quo_fix = (div_rem >= 33'(REDUCTION)) ? quo_r + 32'd1 : quo_r;

  assign mag     = (sp_r > FS_POS || sp_r < FS_NEG) ? FS_MAG : sp_abs[MAG_W-1:0];
  assign fwd     = !sp_r[31] && (sp_r != '0);
  assign duty    = (32'(mag) > 32'(cfg.duty_limit)) ? cfg.duty_limit
                                                   : cpmd_pkg::DUTY_W'(mag);
  assign dir_chg = !dir_valid_r[drv_r] || (dir_flag_r[drv_r] != fwd);

  always_comb begin
    unique case (state_r)
      S_MP: begin
        mul_a = 33'(err_r);
        mul_b = 32'(co.kp);
      end
      S_MI: begin
        mul_a = 33'(err_r);
        mul_b = 32'(co.ki);
      end
      S_MD: begin
        mul_a = 33'(err_r) - 33'(perr_cur);
        mul_b = 32'(co.kd);
      end
      S_DIV0: begin
        mul_a = {1'b0, sp_abs};
        mul_b = RECIP;
      end
      S_DIV1: begin
        mul_a = {1'b0, prod_r[63:32]};
        mul_b = 32'(REDUCTION);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    lp_nxt         = lp_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          lp_nxt    = LOOP_POS;
          state_nxt = drv_in_ok ? S_ERR : S_OUT;
        end
      end
      S_ERR: begin
        if (loop_en) begin
          state_nxt = S_MP;
        end else if (lp_r == LOOP_POS) begin
          lp_nxt = LOOP_SPD;
        end else if (lp_r == LOOP_SPD) begin
          state_nxt = S_DIV0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MP: state_nxt = S_MI;
      S_MI: state_nxt = S_MD;
      S_MD: state_nxt = S_SUM;
      S_SUM: begin
        if (lp_r == LOOP_POS) begin
          lp_nxt    = LOOP_SPD;
          state_nxt = S_ERR;
        end else if (lp_r == LOOP_SPD) begin
          state_nxt = S_DIV0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV0: state_nxt = S_DIV1;
      S_DIV1: state_nxt = S_DIV2;
      S_DIV2: begin
        lp_nxt    = LOOP_CUR;
        state_nxt = S_ERR;
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lp_r         <= LOOP_POS;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lp_r         <= lp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DRIVES; d++) begin
        last_pos_r[d]  <= '0;
        dir_flag_r[d]  <= 1'b0;
        dir_valid_r[d] <= 1'b0;
        for (int l = 0; l < cpmd_pkg::LOOPS; l++) begin
          integ_r[d][l] <= '0;
          perr_r[d][l]  <= '0;
        end
      end
    end else begin
      if (accept && drv_in_ok) begin
        last_pos_r[drv_in] <= pos_in;
      end
      if (state_r == S_MD && co.ki != '0) begin
        integ_r[drv_r][lp_r] <= integ_nxt;
      end
      if (state_r == S_SUM && co.kd != '0) begin
        perr_r[drv_r][lp_r] <= err_r;
      end
      if (state_r == S_OUT && out_free && drv_ok_r) begin
        dir_flag_r[drv_r]  <= fwd;
        dir_valid_r[drv_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drv_r    <= drv_in;
      drv_ok_r <= drv_in_ok;
      pos_r    <= pos_in;
      target_r <= $signed(in_tdata[79:48]);
      torque_r <= $signed(in_tdata[95:80]);
      cur_fb_r <= cur_fb_in;
      speed_r  <= speed_in;
    end
    unique case (state_r)
      S_ERR: begin
        if (loop_en) begin
          err_r <= sat32(50'(err_raw));
        end else if (lp_r == LOOP_POS) begin
          sp_r <= target_r;
        end
      end
      S_MI:   pterm_r <= $signed(prod_r[47:8]);
      S_SUM:  sp_r    <= sat32(50'(pterm_r) + 50'(integ_cur) + 50'(dterm));
      S_DIV1: quo_r   <= prod_r[63:32];
      S_DIV2: sp_r    <= sp_neg ? 32'(-quo_fix) : quo_fix;
      S_OUT: begin
        if (out_free) begin
          out_tdata_r <= drv_ok_r ? {3'b000, dir_chg, fwd, duty} : '0;
        end
      end
      default: ;
    endcase
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start the sequencer");

  a_loop_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lp_r == LOOP_POS || lp_r == LOOP_SPD || lp_r == LOOP_CUR))
    else $error("loop index out of range");

  a_div_single_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> (div_rem < 33'(2 * REDUCTION)))
    else $error("reciprocal quotient needs more than one correction");

  a_duty_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[cpmd_pkg::DUTY_W-1:0] <= cfg.duty_limit))
    else $error("duty exceeds the configured limit");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_tvalid_r && state_r == S_IDLE))
    else $error("finished tick did not reach the output register");

endmodule
`default_nettype wire

// ----- bench/cascaded_pid_motor_drive_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_pid_motor_drive_test
// Drives control ticks into the position, speed and current PID cascade and
// checks every duty, direction and direction-change result against a
// cycle-free model of the cascade kept inside this bench. Directed ticks
// cover field extremes, speed overflow, every loop-enable combination and
// extreme coefficient settings. Random phases follow with new settings,
// mostly smooth per-drive trajectories and some random ticks, under random
// idling on each side in most phases.
// ----------------------------------------------------------------------------
module cascaded_pid_motor_drive_test;

  localparam int     DRIVE_COUNT    = 4;
  localparam int     FULL_SCALE     = 1024;
  localparam int     CURRENT_OFFSET = 0;
  localparam int     REDUCTION_RATIO = 1;
  localparam int     DRAIN_CYCLES   = 25;
  localparam int     CYCLE_LIMIT    = 1000000;
  localparam longint INT_MAX        = 64'sd2147483647;
  localparam longint INT_MIN        = -64'sd2147483648;

  typedef struct {
    logic [1:0]         drive;
    logic signed [31:0] pos;
    logic signed [15:0] cur;
    logic signed [31:0] target;
    logic signed [15:0] torque;
  } tick_t;

  typedef struct {
    logic [10:0] duty;
    logic        forward;
    logic        changed;
  } drive_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [95:0]                     in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [15:0]                     out_tdata;
  logic                            cfg_wen;
  logic [cpmd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cpmd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  cpmd_pkg::loop_coeffs_t pos_coeffs;
  cpmd_pkg::loop_coeffs_t spd_coeffs;
  cpmd_pkg::loop_coeffs_t cur_coeffs;
  logic [2:0]    loop_en;
  logic [10:0]   duty_lim;
  int            last_pos [DRIVE_COUNT];
  int            integ [DRIVE_COUNT][3];
  int            prev_err [DRIVE_COUNT][3];
  logic          dir_flag [DRIVE_COUNT];
  logic          dir_valid [DRIVE_COUNT];

  drive_result_t duty_expect_q[$];
  int            trk_pos [DRIVE_COUNT];
  int            trk_tgt [DRIVE_COUNT];
  int            err_count;
  int            cycle_count;
  int            hold_req;
  int            rx_wait;
  bit            gaps_on;
  bit            rx_stall_on;

  cascaded_pid_motor_drive #(
    .DRIVES(DRIVE_COUNT),
    .PWM_FULL_SCALE(FULL_SCALE),
    .CURRENT_ZERO(CURRENT_OFFSET),
    .REDUCTION(REDUCTION_RATIO)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > INT_MAX) return INT_MAX;
    if (v < INT_MIN) return INT_MIN;
    return v;
  endfunction

  // Q8.8 product, rounded toward minus infinity.
  function automatic longint qmul(input longint s, input logic [15:0] g);
    longint gl;
    gl = longint'({48'd0, g});
    return (s * gl) >>> 8;
  endfunction

  function automatic longint pid_stage(input int drv, input int lp,
                                       input cpmd_pkg::loop_coeffs_t c,
                                       input longint err_in);
    longint e;
    longint acc;
    longint deriv;
    longint lim;
    e = sat32(err_in);
    deriv = 0;
    lim = longint'({48'd0, c.lim});
    if (c.ki != 16'd0) begin
      acc = sat32(integ[drv][lp] + qmul(e, c.ki));
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ[drv][lp] = int'(acc);
    end
    if (c.kd != 16'd0) begin
      deriv = qmul(e - prev_err[drv][lp], c.kd);
      prev_err[drv][lp] = int'(e);
    end
    return sat32(qmul(e, c.kp) + integ[drv][lp] + deriv);
  endfunction

  function automatic void predict_drive_tick(input tick_t t);
    drive_result_t r;
    int            d;
    longint        p;
    longint        fb;
    longint        spd;
    longint        spd_sp;
    longint        cur_sp;
    longint        outv;
    longint        mag;
    logic          fwd;
    r = '{duty: 11'd0, forward: 1'b0, changed: 1'b0};
    d = int'(t.drive);
    if (d >= DRIVE_COUNT) begin
      duty_expect_q.push_back(r);
      return;
    end
    p = t.pos;
    fb = t.cur;
    if (fb < 0) fb = -fb;
    fb = fb - CURRENT_OFFSET;
    spd = sat32(p - last_pos[d]);
    last_pos[d] = int'(p);
    if (loop_en[0]) spd_sp = pid_stage(d, 0, pos_coeffs, longint'(t.target) - p);
    else spd_sp = t.target;
    if (loop_en[1]) cur_sp = pid_stage(d, 1, spd_coeffs, spd_sp - spd);
    else cur_sp = spd_sp;
    if (loop_en[2]) begin
      outv = pid_stage(d, 2, cur_coeffs, cur_sp / REDUCTION_RATIO + longint'(t.torque) - fb);
    end else begin
      outv = cur_sp / REDUCTION_RATIO;
    end
    if (outv > FULL_SCALE) outv = FULL_SCALE;
    else if (outv < -FULL_SCALE) outv = -FULL_SCALE;
    fwd = (outv > 0);
    r.changed = !dir_valid[d] || (dir_flag[d] != fwd);
    dir_flag[d] = fwd;
    dir_valid[d] = 1'b1;
    mag = (outv < 0) ? -outv : outv;
    if (mag > longint'({53'd0, duty_lim})) mag = longint'({53'd0, duty_lim});
    r.duty = mag[10:0];
    r.forward = fwd;
    duty_expect_q.push_back(r);
  endfunction

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (duty_expect_q.size() == 0) begin
        $error("result transaction with no expectation: tdata %h", out_tdata);
        err_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (out_tdata[10:0] !== want.duty) begin
          $error("duty mismatch: expected %0d, actual %0d", want.duty, out_tdata[10:0]);
          err_count++;
        end
        if (out_tdata[11] !== want.forward) begin
          $error("forward mismatch: expected %0d, actual %0d", want.forward, out_tdata[11]);
          err_count++;
        end
        if (out_tdata[12] !== want.changed) begin
          $error("direction_changed mismatch: expected %0d, actual %0d",
                 want.changed, out_tdata[12]);
          err_count++;
        end
        if (out_tdata[15:13] !== 3'd0) begin
          $error("padding mismatch: expected 0, actual %0d", out_tdata[15:13]);
          err_count++;
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    out_tready = 1'b0;
    rx_wait = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        rx_wait = hold_req;
        hold_req = 0;
      end else if (rx_wait == 0 && rx_stall_on) begin
        rx_wait = gap_len();
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_tick(input tick_t t);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {t.torque, t.target, t.cur, t.pos};
    in_tuser <= t.drive;
    do @(posedge clk); while (!in_tready);
    predict_drive_tick(t);
    if (gaps_on) idle_for(gap_len());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [cpmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cpmd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      cpmd_pkg::CFG_POS_COEFFS:   pos_coeffs = data;
      cpmd_pkg::CFG_SPD_COEFFS:   spd_coeffs = data;
      cpmd_pkg::CFG_CUR_COEFFS:   cur_coeffs = data;
      cpmd_pkg::CFG_LOOP_ENABLES: loop_en = data[2:0];
      cpmd_pkg::CFG_DUTY_LIMIT:   duty_lim = data[10:0];
      default: ;
    endcase
  endtask

  task automatic set_loops(input cpmd_pkg::loop_coeffs_t pc, input cpmd_pkg::loop_coeffs_t sc,
                           input cpmd_pkg::loop_coeffs_t cc, input logic [2:0] en,
                           input logic [10:0] dl);
    drain_results();
    cfg_write(cpmd_pkg::CFG_POS_COEFFS, pc);
    cfg_write(cpmd_pkg::CFG_SPD_COEFFS, sc);
    cfg_write(cpmd_pkg::CFG_CUR_COEFFS, cc);
    cfg_write(cpmd_pkg::CFG_LOOP_ENABLES, {61'd0, en});
    cfg_write(cpmd_pkg::CFG_DUTY_LIMIT, {53'd0, dl});
  endtask

  function automatic logic [15:0] rand_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 75) return 16'($urandom_range(1, 64));
    if (r < 90) return 16'($urandom_range(65, 1024));
    return 16'($urandom);
  endfunction

  function automatic cpmd_pkg::loop_coeffs_t rand_coeffs();
    cpmd_pkg::loop_coeffs_t c;
    int                     r;
    c.kp = rand_gain();
    c.ki = rand_gain();
    c.kd = rand_gain();
    r = $urandom_range(0, 99);
    if (r < 15) c.lim = 16'd0;
    else if (r < 75) c.lim = 16'($urandom_range(1, 3000));
    else c.lim = 16'($urandom);
    return c;
  endfunction

  // Mostly a smooth random walk per drive with an occasionally moved target, plus some random ticks.
  function automatic tick_t rand_tick(input int noise_pct);
    tick_t t;
    int    d;
    d = $urandom_range(0, DRIVE_COUNT - 1);
    t.drive = d[1:0];
    if ($urandom_range(0, 99) >= noise_pct) begin
      trk_pos[d] = trk_pos[d] + (int'($urandom_range(0, 400)) - 200);
      if ($urandom_range(0, 9) == 0) begin
        trk_tgt[d] = trk_pos[d] + (int'($urandom_range(0, 4000)) - 2000);
      end
      t.pos = trk_pos[d];
      t.target = trk_tgt[d];
      t.cur = 16'(int'($urandom_range(0, 1000)) - 500);
      t.torque = 16'(int'($urandom_range(0, 600)) - 300);
    end else begin
      t.pos = $urandom;
      t.cur = 16'($urandom);
      t.target = $urandom;
      t.torque = 16'($urandom);
    end
    return t;
  endfunction

  function automatic tick_t mk_tick(input int d, input int p, input int c, input int tg,
                                    input int tq);
    tick_t t;
    t.drive = d[1:0];
    t.pos = p;
    t.cur = c[15:0];
    t.target = tg;
    t.torque = tq[15:0];
    return t;
  endfunction

  function automatic cpmd_pkg::loop_coeffs_t mk_coeffs(input logic [15:0] kp,
                                                       input logic [15:0] ki,
                                                       input logic [15:0] kd,
                                                       input logic [15:0] lim);
    cpmd_pkg::loop_coeffs_t c;
    c.kp = kp;
    c.ki = ki;
    c.kd = kd;
    c.lim = lim;
    return c;
  endfunction

  task automatic test_reset_state();
    send_tick(mk_tick(0, 10, 5, 300, 0));
    send_tick(mk_tick(3, -20, -7, -300, 12));
  endtask

  task automatic test_field_extremes();
    set_loops(mk_coeffs(16'h0100, 16'h0010, 16'h0040, 16'h0400),
              mk_coeffs(16'h0100, 16'h0008, 16'h0020, 16'h0200),
              mk_coeffs(16'h0080, 16'h0004, 16'h0010, 16'h0100), 3'd7, 11'd1024);
    send_tick(mk_tick(0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 100, 0, 400, 0));
    send_tick(mk_tick(0, 100, 0, -400, 0));
    send_tick(mk_tick(1, int'(INT_MIN), -32768, int'(INT_MAX), 32767));
    send_tick(mk_tick(1, int'(INT_MAX), 32767, int'(INT_MIN), -32768));
    send_tick(mk_tick(2, int'(INT_MAX), 0, int'(INT_MAX), 0));
    send_tick(mk_tick(2, int'(INT_MIN), -1, int'(INT_MIN), -1));
    send_tick(mk_tick(3, -1, 1, 0, -32768));
  endtask

  task automatic test_loop_enables();
    for (int en = 0; en < 8; en++) begin
      set_loops(mk_coeffs(16'h0020, 16'h0004, 16'h0010, 16'h0800),
                mk_coeffs(16'h0040, 16'h0002, 16'h0008, 16'h0400),
                mk_coeffs(16'h0100, 16'h0001, 16'h0004, 16'h0200), en[2:0], 11'd700);
      send_tick(rand_tick(0));
    end
  endtask

  task automatic test_extreme_settings();
    set_loops(mk_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
              mk_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
              mk_coeffs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 3'd7, 11'd1024);
    send_tick(mk_tick(1, 5000, 300, -5000, 0));
    send_tick(mk_tick(1, -5000, -300, 5000, 0));
    set_loops(mk_coeffs(16'h0000, 16'h0000, 16'h0000, 16'h0000),
              mk_coeffs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000),
              mk_coeffs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF), 3'd7, 11'd0);
    send_tick(mk_tick(2, 40, 100, 900, 50));
    send_tick(mk_tick(2, -40, -100, -900, -50));
  endtask

  task automatic test_backpressure();
    set_loops(rand_coeffs(), rand_coeffs(), rand_coeffs(), 3'd7, 11'd1024);
    gaps_on = 1'b0;
    @(posedge clk);
    hold_req = 300;
    repeat (10) send_tick(rand_tick(25));
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (5) send_tick(rand_tick(25));
    drain_results();
    repeat (5) send_tick(rand_tick(25));
  endtask

  task automatic test_random_traffic();
    logic [10:0] dl;
    int          r;
    for (int phase = 0; phase < 15; phase++) begin
      r = $urandom_range(0, 9);
      if (r == 0) dl = 11'd0;
      else if (r < 3) dl = 11'd1024;
      else dl = 11'($urandom_range(0, 1024));
      set_loops(rand_coeffs(), rand_coeffs(), rand_coeffs(),
                (phase == 0) ? 3'd7 : 3'($urandom_range(0, 7)), dl);
      gaps_on = (phase % 3) != 2;
      rx_stall_on = (phase % 4) != 3;
      repeat (100) send_tick(rand_tick(25));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_count = 0;
    cycle_count = 0;
    hold_req = 0;
    gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    pos_coeffs = '0;
    spd_coeffs = '0;
    cur_coeffs = '0;
    loop_en = cpmd_pkg::ENABLES_RESET;
    duty_lim = cpmd_pkg::DUTY_LIMIT_RESET;
    for (int d = 0; d < DRIVE_COUNT; d++) begin
      last_pos[d] = 0;
      dir_flag[d] = 1'b0;
      dir_valid[d] = 1'b0;
      trk_pos[d] = 0;
      trk_tgt[d] = 0;
      for (int j = 0; j < 3; j++) begin
        integ[d][j] = 0;
        prev_err[d][j] = 0;
      end
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_field_extremes();
    test_loop_enables();
    test_extreme_settings();
    test_backpressure();
    test_pause_until_drained();
    test_random_traffic();
    drain_results();

    if (err_count == 0 && duty_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
